/* rtl/dkt_pkg.sv */
// Shared types and codes for the dense keyed table.
package dkt_pkg;

    // Width of an entity id and of the dense position field.
    localparam int ID_W  = 32;
    localparam int IDX_W = 7;

    // Operation codes carried with each request.
    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_DUP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_MISSING = 3'd4,
        ST_RANGE   = 3'd5
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // Request accepted: search and issue the memory read.
        logic commit;   // Execute the request, update the table, load the result.
    } t_dp_cmd;

endpackage

/* rtl/dkt_ctrl.sv */
// Controller for the dense keyed table: sequences accept and execute cycles.
module dkt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_strobe,
    output dkt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_strobe;

    // Next state: the execute state follows every accepted request, and idle follows execute.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state == S_EXEC);
            r_strobe <= (r_state == S_EXEC);
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_start;
        o_cmd.commit  = (r_state == S_EXEC);
    end

    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

/* rtl/dkt_datapath.sv */
// Datapath for the dense keyed table: key compare lanes, entry memories, result registers.
module dkt_datapath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 64,
    parameter int ADDR_W     = 6,
    parameter int CNT_W      = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dkt_pkg::t_dp_cmd           i_cmd,
    input  logic                       i_cfg_we,
    input  logic [dkt_pkg::ID_W-1:0]   i_cfg_data,
    input  logic [1:0]                 i_func,
    input  logic [dkt_pkg::ID_W-1:0]   i_entity_id,
    input  logic [DATA_WIDTH-1:0]      i_data_in,
    input  logic [dkt_pkg::IDX_W-1:0]  i_slot_index,
    output logic [2:0]                 o_status,
    output logic [DATA_WIDTH-1:0]      o_data_out,
    output logic [dkt_pkg::ID_W-1:0]   o_id_out,
    output logic [CNT_W-1:0]           o_entry_count
);

    localparam int EXT_W = (ADDR_W > dkt_pkg::IDX_W) ? ADDR_W : dkt_pkg::IDX_W;
    localparam int CMP_W = (CNT_W > dkt_pkg::IDX_W) ? CNT_W : dkt_pkg::IDX_W;

    // Configuration and fill state.
    logic [dkt_pkg::ID_W-1:0] r_invalid_id;
    logic [CNT_W-1:0]         r_fill;
    logic [CNT_W-1:0]         n_fill;

    // Key copies for the parallel compare, plus memories for indexed reads.
    logic [dkt_pkg::ID_W-1:0] r_key [CAPACITY];
    logic [dkt_pkg::ID_W-1:0] mem_key [CAPACITY];
    logic [DATA_WIDTH-1:0]    mem_data [CAPACITY];
    logic [dkt_pkg::ID_W-1:0] r_rd_key;
    logic [DATA_WIDTH-1:0]    r_rd_data;

    // Captured request.
    dkt_pkg::t_func           r_func;
    logic [dkt_pkg::ID_W-1:0] r_id;
    logic [DATA_WIDTH-1:0]    r_data;
    logic                     r_idx_ok;
    logic                     r_hit;
    logic [ADDR_W-1:0]        r_slot;

    // Search and address signals in the accept cycle.
    logic [CAPACITY-1:0]      match;
    logic                     hit_c;
    logic [ADDR_W-1:0]        slot_c;
    logic [CNT_W-1:0]         fill_m1;
    logic [ADDR_W-1:0]        last_addr;
    logic [EXT_W-1:0]         idx_ext;
    logic [ADDR_W-1:0]        idx_addr;
    logic                     idx_ok_c;
    logic [ADDR_W-1:0]        rd_addr;

    // Execute-cycle signals.
    logic                     we;
    logic [ADDR_W-1:0]        wr_addr;
    logic [dkt_pkg::ID_W-1:0] wr_key;
    logic [DATA_WIDTH-1:0]    wr_data;
    dkt_pkg::t_status         n_status;
    logic [DATA_WIDTH-1:0]    n_data_out;
    logic [dkt_pkg::ID_W-1:0] n_id_out;

    // Result registers.
    dkt_pkg::t_status         r_status;
    logic [DATA_WIDTH-1:0]    r_data_out;
    logic [dkt_pkg::ID_W-1:0] r_id_out;
    logic [CNT_W-1:0]         r_entry_count;

    // Compare lanes: each occupied entry checks its key against the request id.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < r_fill) && (r_key[i] == i_entity_id);
        end
    end

    // Keys are unique, so the slot is the OR of the matching lane numbers.
    always_comb begin
        slot_c = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            slot_c = slot_c | (match[i] ? ADDR_W'(i) : '0);
        end
        hit_c = |match;
    end

    // Read address: the found slot, the last entry, the requested index, or zero for add.
    always_comb begin
        fill_m1   = r_fill - CNT_W'(1);
        last_addr = fill_m1[ADDR_W-1:0];
        idx_ext   = EXT_W'(i_slot_index);
        idx_addr  = idx_ext[ADDR_W-1:0];
        idx_ok_c  = CMP_W'(i_slot_index) < CMP_W'(r_fill);
        unique case (dkt_pkg::t_func'(i_func))
            dkt_pkg::FUNC_ADD:    rd_addr = '0;
            dkt_pkg::FUNC_LOOKUP: rd_addr = slot_c;
            dkt_pkg::FUNC_REMOVE: rd_addr = last_addr;
            dkt_pkg::FUNC_READ:   rd_addr = idx_addr;
            default:              rd_addr = '0;
        endcase
    end

    // Capture the request and the search outcome.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func   <= dkt_pkg::t_func'(i_func);
            r_id     <= i_entity_id;
            r_data   <= i_data_in;
            r_idx_ok <= idx_ok_c;
            r_hit    <= hit_c;
            r_slot   <= slot_c;
        end
    end

    // Execute: decide the status, the table write and the result fields.
    always_comb begin
        n_status   = dkt_pkg::ST_OK;
        n_data_out = '0;
        n_id_out   = r_invalid_id;
        n_fill     = r_fill;
        we         = 1'b0;
        wr_addr    = r_fill[ADDR_W-1:0];
        wr_key     = r_id;
        wr_data    = r_data;
        unique case (r_func)
            dkt_pkg::FUNC_ADD: begin
                if (r_id == r_invalid_id) begin
                    n_status = dkt_pkg::ST_INVALID;
                end else if (r_hit) begin
                    n_status = dkt_pkg::ST_DUP;
                end else if (r_fill == CNT_W'(CAPACITY)) begin
                    n_status = dkt_pkg::ST_FULL;
                end else begin
                    we     = 1'b1;
                    n_fill = r_fill + CNT_W'(1);
                end
            end
            dkt_pkg::FUNC_LOOKUP: begin
                if (!r_hit) begin
                    n_status = dkt_pkg::ST_MISSING;
                end else begin
                    n_data_out = r_rd_data;
                end
            end
            dkt_pkg::FUNC_REMOVE: begin
                if (!r_hit) begin
                    n_status = dkt_pkg::ST_MISSING;
                end else begin
                    // Move the last entry into the freed slot.
                    we      = 1'b1;
                    wr_addr = r_slot;
                    wr_key  = r_rd_key;
                    wr_data = r_rd_data;
                    n_fill  = r_fill - CNT_W'(1);
                end
            end
            dkt_pkg::FUNC_READ: begin
                if (!r_idx_ok) begin
                    n_status = dkt_pkg::ST_RANGE;
                end else begin
                    n_data_out = r_rd_data;
                    n_id_out   = r_rd_key;
                end
            end
            default: begin
                n_status = dkt_pkg::ST_OK;
            end
        endcase
    end

    // Entry memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we) begin
            mem_key[wr_addr]  <= wr_key;
            mem_data[wr_addr] <= wr_data;
        end
        if (i_cmd.capture) begin
            r_rd_key  <= mem_key[rd_addr];
            r_rd_data <= mem_data[rd_addr];
        end
    end

    // Compare-lane key copies.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we) begin
            r_key[wr_addr] <= wr_key;
        end
    end

    // Fill count and the invalid id register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_invalid_id <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_fill <= n_fill;
            end
            if (i_cfg_we) begin
                r_invalid_id <= i_cfg_data;
            end
        end
    end

    // Result registers, loaded in the execute cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= n_status;
            r_data_out    <= n_data_out;
            r_id_out      <= n_id_out;
            r_entry_count <= n_fill;
        end
    end

    assign o_status      = r_status;
    assign o_data_out    = r_data_out;
    assign o_id_out      = r_id_out;
    assign o_entry_count = r_entry_count;

endmodule

/* rtl/dense_keyed_table_core.sv */
// Top level of the dense keyed table: packed id/data map with swap-on-remove.
//
// Requests: drive the operation, id, data and index with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Operations are add, lookup by id, remove by id and read at a dense index.
// Every transaction gives one result: status, data, id and the entry count,
// shown on the result ports while o_result_strobe is high for one cycle.
// The receiver cannot stall, so results are never held back.
// Timing: the accept cycle compares the id against every stored key in
// parallel and issues the entry memory read; the next cycle (busy high)
// updates the table and loads the result registers. The strobe is
// registered from the execute state, so it rises with the new result.
// No request is taken while busy is high; a new one can be taken in the
// cycle that shows the previous result.
// Configuration: the invalid id is written on its own valid/ready channel
// (ready is always high); write it only while no request is in flight.
// Reset: synchronous, active low; it empties the table and clears the
// invalid id to zero. Entry contents are not cleared, since only occupied
// positions ever reach the outputs.
module dense_keyed_table_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dkt_pkg::ID_W-1:0]             i_cfg_data,
    input  logic [1:0]                           i_func,
    input  logic [dkt_pkg::ID_W-1:0]             i_entity_id,
    input  logic [DATA_WIDTH-1:0]                i_data_in,
    input  logic [dkt_pkg::IDX_W-1:0]            i_slot_index,
    output logic                                 o_result_strobe,
    output logic [2:0]                           o_status,
    output logic [DATA_WIDTH-1:0]                o_data_out,
    output logic [dkt_pkg::ID_W-1:0]             o_id_out,
    output logic [$clog2(CAPACITY+1)-1:0]        o_entry_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    dkt_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    // Controller.
    dkt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_result_strobe),
        .o_cmd    (cmd)
    );

    // Datapath.
    dkt_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_entity_id   (i_entity_id),
        .i_data_in     (i_data_in),
        .i_slot_index  (i_slot_index),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_id_out      (o_id_out),
        .o_entry_count (o_entry_count)
    );

    // An accepted transaction makes the block busy for exactly one cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one execute cycle");

    // Every execute cycle is followed by a result strobe.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_result_strobe)
        else $error("result strobe missing after execute cycle");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the dense keyed table core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 64;
    localparam int ID_W       = dkt_pkg::ID_W;
    localparam int IDX_W      = dkt_pkg::IDX_W;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POOL_SIZE  = 96;
    localparam int CFG_QUIET  = 4;
    localparam int TAIL_WAIT  = 8;
    localparam int PRINT_CAP  = 50;

    // One queued stimulus entry: either a request or a write of the invalid id.
    typedef struct {
        bit                    is_cfg;
        dkt_pkg::t_func        func;
        logic [ID_W-1:0]       id;
        logic [DATA_WIDTH-1:0] data;
        logic [IDX_W-1:0]      idx;
        int unsigned           gap;
    } t_op_item;

    // One reply of the block.
    typedef struct {
        dkt_pkg::t_status      status;
        logic [DATA_WIDTH-1:0] data;
        logic [ID_W-1:0]       id;
        logic [CNT_W-1:0]      count;
    } t_reply;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [ID_W-1:0]       i_cfg_data   = '0;
    dkt_pkg::t_func        i_func       = dkt_pkg::FUNC_ADD;
    logic [ID_W-1:0]       i_entity_id  = '0;
    logic [DATA_WIDTH-1:0] i_data_in    = '0;
    logic [IDX_W-1:0]      i_slot_index = '0;
    logic                  o_result_strobe;
    logic [2:0]            o_status;
    logic [DATA_WIDTH-1:0] o_data_out;
    logic [ID_W-1:0]       o_id_out;
    logic [CNT_W-1:0]      o_entry_count;

    // Stimulus still to be driven, and replies still to arrive.
    t_op_item op_queue[$];
    t_reply   reply_queue[$];

    // Predictor copy of the table.
    logic [ID_W-1:0]       map_keys [CAPACITY];
    logic [DATA_WIDTH-1:0] map_data [CAPACITY];
    int                    map_count   = 0;
    logic [ID_W-1:0]       map_invalid = '0;

    // Driver bookkeeping.
    int unsigned in_flight    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left     = 0;

    // Generator view of the ids in play.
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    logic [ID_W-1:0] gen_invalid = '0;
    int unsigned     mismatch_count = 0;

    dense_keyed_table_core #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_entity_id    (i_entity_id),
        .i_data_in      (i_data_in),
        .i_slot_index   (i_slot_index),
        .o_result_strobe(o_result_strobe),
        .o_status       (o_status),
        .o_data_out     (o_data_out),
        .o_id_out       (o_id_out),
        .o_entry_count  (o_entry_count)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Applies one accepted request to the predictor table and returns its reply.
    function automatic t_reply apply_request(input dkt_pkg::t_func f,
                                             input logic [ID_W-1:0] id,
                                             input logic [DATA_WIDTH-1:0] din,
                                             input logic [IDX_W-1:0] idx);
        t_reply r;
        int     slot;
        int     last;
        r.status = dkt_pkg::ST_OK;
        r.data   = '0;
        r.id     = map_invalid;
        slot     = -1;
        for (int i = 0; i < map_count; i++) begin
            if (slot < 0 && map_keys[i] == id) begin
                slot = i;
            end
        end
        case (f)
            dkt_pkg::FUNC_ADD: begin
                if (id == map_invalid) begin
                    r.status = dkt_pkg::ST_INVALID;
                end else if (slot >= 0) begin
                    r.status = dkt_pkg::ST_DUP;
                end else if (map_count >= CAPACITY) begin
                    r.status = dkt_pkg::ST_FULL;
                end else begin
                    map_keys[map_count] = id;
                    map_data[map_count] = din;
                    map_count++;
                end
            end
            dkt_pkg::FUNC_LOOKUP: begin
                if (slot < 0) begin
                    r.status = dkt_pkg::ST_MISSING;
                end else begin
                    r.data = map_data[slot];
                end
            end
            dkt_pkg::FUNC_REMOVE: begin
                if (slot < 0) begin
                    r.status = dkt_pkg::ST_MISSING;
                end else begin
                    // The last entry fills the hole.
                    last           = map_count - 1;
                    map_keys[slot] = map_keys[last];
                    map_data[slot] = map_data[last];
                    map_count      = last;
                end
            end
            default: begin
                if (int'(idx) >= map_count) begin
                    r.status = dkt_pkg::ST_RANGE;
                end else begin
                    r.data = map_data[idx];
                    r.id   = map_keys[idx];
                end
            end
        endcase
        r.count = CNT_W'(map_count);
        return r;
    endfunction

    // Idle length after an item: mostly short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Ids mostly come from a shared pool so that lookups and removes hit.
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 92) return gen_invalid;
        return $urandom();
    endfunction

    // Data words are random with the occasional extreme.
    function automatic logic [DATA_WIDTH-1:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic push_req(input dkt_pkg::t_func f, input logic [ID_W-1:0] id,
                            input logic [DATA_WIDTH-1:0] din, input logic [IDX_W-1:0] idx,
                            input int unsigned gap);
        t_op_item it;
        it.is_cfg = 1'b0;
        it.func   = f;
        it.id     = id;
        it.data   = din;
        it.idx    = idx;
        it.gap    = gap;
        op_queue.push_back(it);
    endtask

    task automatic push_cfg(input logic [ID_W-1:0] value);
        t_op_item it;
        it.is_cfg   = 1'b1;
        it.func     = dkt_pkg::FUNC_ADD;
        it.id       = value;
        it.data     = '0;
        it.idx      = '0;
        it.gap      = pick_gap();
        gen_invalid = value;
        op_queue.push_back(it);
    endtask

    // One random request; mode 0 fills the table, 1 is balanced, 2 drains it.
    task automatic push_random(input int mode, input int unsigned gap);
        int unsigned      r;
        dkt_pkg::t_func   f;
        logic [IDX_W-1:0] idx;
        r = $urandom_range(0, 99);
        case (mode)
            0:       f = (r < 60) ? dkt_pkg::FUNC_ADD : (r < 75) ? dkt_pkg::FUNC_LOOKUP :
                         (r < 85) ? dkt_pkg::FUNC_REMOVE : dkt_pkg::FUNC_READ;
            1:       f = (r < 30) ? dkt_pkg::FUNC_ADD : (r < 55) ? dkt_pkg::FUNC_LOOKUP :
                         (r < 75) ? dkt_pkg::FUNC_REMOVE : dkt_pkg::FUNC_READ;
            default: f = (r < 15) ? dkt_pkg::FUNC_ADD : (r < 35) ? dkt_pkg::FUNC_LOOKUP :
                         (r < 80) ? dkt_pkg::FUNC_REMOVE : dkt_pkg::FUNC_READ;
        endcase
        if ($urandom_range(0, 9) < 7) begin
            idx = IDX_W'($urandom_range(0, CAPACITY));
        end else begin
            idx = IDX_W'($urandom_range(0, 127));
        end
        push_req(f, pick_id(), pick_data(), idx, gap);
    endtask

    // Driver: launches queued items, predicts each accepted transaction and
    // writes the invalid id only when no reply is outstanding.
    always @(posedge i_clk) begin : drive_proc
        t_op_item    item;
        bit          req_taken;
        bit          cfg_taken;
        bit          lane_free;
        bit          next_start;
        bit          next_cfg;
        if (i_rst_n) begin
            req_taken = start && !busy;
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (req_taken) begin
                reply_queue.push_back(apply_request(i_func, i_entity_id, i_data_in,
                                                    i_slot_index));
            end
            if (cfg_taken) begin
                map_invalid = i_cfg_data;
            end
            in_flight = in_flight + (req_taken ? 1 : 0) - (o_result_strobe ? 1 : 0);
            lane_free = (!start || req_taken) && (!i_cfg_valid || cfg_taken);
            if (in_flight == 0 && lane_free && !req_taken) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end

            if (lane_free) begin
                next_start = 1'b0;
                next_cfg   = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (op_queue.size() > 0) begin
                    item = op_queue[0];
                    if (!item.is_cfg) begin
                        next_start   = 1'b1;
                        i_func       <= item.func;
                        i_entity_id  <= item.id;
                        i_data_in    <= item.data;
                        i_slot_index <= item.idx;
                        gap_left     = item.gap;
                        void'(op_queue.pop_front());
                    end else if (in_flight == 0 && quiet_cycles >= CFG_QUIET) begin
                        next_cfg   = 1'b1;
                        i_cfg_data <= item.id;
                        gap_left   = item.gap;
                        void'(op_queue.pop_front());
                    end
                end
                start       <= next_start;
                i_cfg_valid <= next_cfg;
            end
        end
    end

    // Monitor: every strobed reply is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        t_reply want;
        if (i_rst_n && o_result_strobe) begin
            if (reply_queue.size() == 0) begin
                report_mismatch("reply with no request outstanding");
            end else begin
                want = reply_queue.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                end
                if (o_data_out !== want.data) begin
                    report_mismatch($sformatf("data_out got %h want %h",
                                              o_data_out, want.data));
                end
                if (o_id_out !== want.id) begin
                    report_mismatch($sformatf("id_out got %h want %h",
                                              o_id_out, want.id));
                end
                if (o_entry_count !== want.count) begin
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              o_entry_count, want.count));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : main_proc
        logic [ID_W-1:0] phase_cfg [6];
        int              phase_mode [6];
        bit              no_idle;
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = $urandom();
        end
        id_pool[0] = '1;
        id_pool[1] = 32'd1;

        // Directed part: refusals, extremes, range checks and the stale invalid id.
        push_req(dkt_pkg::FUNC_ADD,    32'd0,         '1, '0, pick_gap());
        push_req(dkt_pkg::FUNC_ADD,    32'hFFFF_FFFF, '1, '1, pick_gap());
        push_req(dkt_pkg::FUNC_ADD,    32'd1,         '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_ADD,    32'd1,         '1, '0, pick_gap());
        push_req(dkt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_LOOKUP, 32'd5,         '1, '1, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd0, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd1, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd2, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd127, pick_gap());
        push_req(dkt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd0, pick_gap());
        push_req(dkt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_LOOKUP, 32'd0,         '0, '0, pick_gap());
        // The stored id 1 becomes the invalid id; it must still be found.
        push_cfg(32'd1);
        push_req(dkt_pkg::FUNC_LOOKUP, 32'd1,         '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_ADD,    32'd1,         '1, '0, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd0, pick_gap());
        push_req(dkt_pkg::FUNC_ADD,    32'd0,         '1, '0, pick_gap());
        push_req(dkt_pkg::FUNC_REMOVE, 32'd1,         '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_REMOVE, 32'd0,         '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_REMOVE, 32'd0,         '0, '0, pick_gap());
        push_req(dkt_pkg::FUNC_READ,   32'd0,         '0, 7'd0, pick_gap());
        push_req(dkt_pkg::FUNC_LOOKUP, 32'd1,         '0, '0, pick_gap());

        // Random phases, each under its own invalid id.
        phase_cfg[0] = '1;                               phase_mode[0] = 0;
        phase_cfg[1] = '0;                               phase_mode[1] = 1;
        phase_cfg[2] = id_pool[$urandom_range(2, POOL_SIZE - 1)]; phase_mode[2] = 2;
        phase_cfg[3] = $urandom();                       phase_mode[3] = 0;
        phase_cfg[4] = id_pool[$urandom_range(2, POOL_SIZE - 1)]; phase_mode[4] = 1;
        phase_cfg[5] = $urandom();                       phase_mode[5] = 2;
        no_idle = 1'b0;
        for (int p = 0; p < 6; p++) begin
            push_cfg(phase_cfg[p]);
            for (int k = 0; k < 250; k++) begin
                if (k % 40 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                push_random(phase_mode[p], no_idle ? 0 : pick_gap());
            end
        end

        // Synchronous reset, asserted once.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all stimulus to be taken and every reply to arrive.
        @(negedge i_clk);
        while (op_queue.size() != 0 || start || i_cfg_valid) begin
            @(negedge i_clk);
        end
        while (reply_queue.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_WAIT) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin : watchdog_proc
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
